### sv/ncq_pkg.sv
// Shared types and constants for the nearest palette color quantizer.
// No dependencies; imported by ncq_dist and the top level of the block.
`timescale 1ns / 1ps

package ncq_pkg;

  localparam int FUNC_W  = 2;
  localparam int CHAN_W  = 8;
  localparam int DIST_W  = 18;
  localparam int THR_W   = 20;
  localparam int OUT_W   = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PREPARE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 2'd2;

  localparam logic [THR_W-1:0] NO_NEIGHBOUR = {THR_W{1'b1}};

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

endpackage

### sv/ncq_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Depends on nothing; used for the palette and the neighbour distance stores.
`timescale 1ns / 1ps

module ncq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ncq_dist.sv
// Squared RGB distance unit: per-channel squares registered, sum after the register.
// Depends on ncq_pkg.
`timescale 1ns / 1ps

module ncq_dist (
  input  logic                       clk,
  input  ncq_pkg::color_t            color_a,
  input  ncq_pkg::color_t            color_b,
  output logic [ncq_pkg::DIST_W-1:0] sq_sum
);

  import ncq_pkg::*;

  logic [CHAN_W-1:0]   abs_r_c, abs_g_c, abs_b_c;
  logic [2*CHAN_W-1:0] sq_red_r, sq_green_r, sq_blue_r;

  always_comb begin
    abs_r_c = (color_a.red > color_b.red) ? (color_a.red - color_b.red)
                                          : (color_b.red - color_a.red);
    abs_g_c = (color_a.green > color_b.green) ? (color_a.green - color_b.green)
                                              : (color_b.green - color_a.green);
    abs_b_c = (color_a.blue > color_b.blue) ? (color_a.blue - color_b.blue)
                                            : (color_b.blue - color_a.blue);
  end

  always_ff @(posedge clk) begin
    sq_red_r   <= abs_r_c * abs_r_c;
    sq_green_r <= abs_g_c * abs_g_c;
    sq_blue_r  <= abs_b_c * abs_b_c;
  end

  assign sq_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

endmodule

### sv/nearest_palette_color_quantizer.sv
// Top level of the nearest palette color quantizer: control sequencer and cache.
// Depends on ncq_pkg, ncq_ram and ncq_dist.
//
//   Channel | Direction | tdata                                   | tuser
//   in_     | input     | entry_index, red, green, blue (32 bits) | func, first_pixel
//   out_    | output    | palette_index (8 bits)                  | none
//
// A load writes one palette entry. A pixel that matches the cached color is answered from
// the cache, one that passes the closeness test returns the cached index, and any other
// pixel starts a full search that reads every palette entry through the single read port
// of the palette RAM. A prepare runs a full search for each entry and stores its nearest
// neighbour distance. Reset invalidates the cache and leaves the RAMs as they are.
// One result register decouples the output; a new item is taken while it is occupied.
`timescale 1ns / 1ps

module nearest_palette_color_quantizer #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,  // entry_index, red, green, blue
  input  logic [2:0]                 in_tuser,  // func, first_pixel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ncq_pkg::OUT_W-1:0]  out_tdata  // palette_index
);

  import ncq_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHK_RD   = 4'd1;
  localparam logic [3:0] S_CHK_WAIT = 4'd2;
  localparam logic [3:0] S_CHK_CMP  = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_PR_RD    = 4'd5;
  localparam logic [3:0] S_PR_REF   = 4'd6;
  localparam logic [3:0] S_PR_WR    = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]       state_r, state_nxt;
  color_t           ref_r, ref_nxt;
  logic             prep_r, prep_nxt;
  color_t           cache_color_r, cache_color_nxt;
  logic [IDX_W-1:0] cache_idx_r, cache_idx_nxt;
  logic             cache_valid_r, cache_valid_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             scan_go_r, scan_go_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic [IDX_W-1:0] s1_idx_r, s1_idx_nxt;
  logic             s2_v_r, s2_v_nxt;
  logic [IDX_W-1:0] s2_idx_r, s2_idx_nxt;
  logic             s2_eq_r, s2_eq_nxt;
  logic [THR_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic              in_xfer;
  logic [FUNC_W-1:0] in_func;
  logic              in_first;
  logic [7:0]        in_entry;
  color_t            in_color;

  logic             pal_we, pal_re, nd_we, nd_re;
  logic [IDX_W-1:0] pal_waddr, pal_raddr, nd_waddr;
  color_t           pal_rdata;
  logic [THR_W-1:0] nd_rdata;
  logic [DIST_W-1:0] sq_dist;
  logic             hit_eff;

  assign in_func   = in_tuser[1:0];
  assign in_first  = in_tuser[2];
  assign in_entry  = in_tdata[7:0];
  assign in_color  = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign pal_we    = in_xfer && (in_func == FUNC_LOAD) &&
                     ({1'b0, in_entry} < 9'(PALETTE_ENTRIES));
  assign pal_waddr = in_entry[IDX_W-1:0];
  assign nd_we     = (state_r == S_PR_WR);
  assign nd_waddr  = i_r;
  assign nd_re     = (state_r == S_CHK_RD);

  ncq_ram #(.WIDTH($bits(color_t)), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (in_color),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  ncq_ram #(.WIDTH(THR_W), .DEPTH(PALETTE_ENTRIES)) u_nd_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (best_r),
    .re    (nd_re),
    .raddr (cache_idx_r),
    .rdata (nd_rdata)
  );

  ncq_dist u_dist (
    .clk     (clk),
    .color_a (pal_rdata),
    .color_b (ref_r),
    .sq_sum  (sq_dist)
  );

  always_comb begin
    state_nxt       = state_r;
    ref_nxt         = ref_r;
    prep_nxt        = prep_r;
    cache_color_nxt = cache_color_r;
    cache_idx_nxt   = cache_idx_r;
    cache_valid_nxt = cache_valid_r;
    cnt_nxt         = cnt_r;
    scan_go_nxt     = scan_go_r;
    i_nxt           = i_r;
    best_nxt        = best_r;
    best_idx_nxt    = best_idx_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    pal_re          = 1'b0;
    pal_raddr       = cnt_r;
    hit_eff         = cache_valid_r && !in_first;

    s1_v_nxt   = 1'b0;
    s1_idx_nxt = cnt_r;
    s2_v_nxt   = s1_v_r;
    s2_idx_nxt = s1_idx_r;
    s2_eq_nxt  = (pal_rdata == ref_r);

    if (s2_v_r && !(prep_r && s2_eq_r) && ({2'b00, sq_dist} < best_r)) begin
      best_nxt     = {2'b00, sq_dist};
      best_idx_nxt = s2_idx_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            FUNC_PREPARE: begin
              prep_nxt  = 1'b1;
              i_nxt     = '0;
              state_nxt = S_PR_RD;
            end
            FUNC_PIXEL: begin
              prep_nxt        = 1'b0;
              ref_nxt         = in_color;
              cache_valid_nxt = hit_eff;
              if (hit_eff && (in_color == cache_color_r)) begin
                res_nxt   = cache_idx_r;
                state_nxt = S_OUT;
              end else if (hit_eff) begin
                state_nxt = S_CHK_RD;
              end else begin
                best_nxt    = NO_NEIGHBOUR;
                cnt_nxt     = '0;
                scan_go_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CHK_RD: begin
        pal_re    = 1'b1;
        pal_raddr = cache_idx_r;
        state_nxt = S_CHK_WAIT;
      end
      S_CHK_WAIT: begin
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if ({sq_dist, 2'b00} < nd_rdata) begin
          res_nxt   = cache_idx_r;
          state_nxt = S_OUT;
        end else begin
          best_nxt    = NO_NEIGHBOUR;
          cnt_nxt     = '0;
          scan_go_nxt = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_go_r) begin
          pal_re      = 1'b1;
          pal_raddr   = cnt_r;
          s1_v_nxt    = 1'b1;
          s1_idx_nxt  = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
          scan_go_nxt = (cnt_r != LAST_IDX);
        end else if (!s1_v_r && !s2_v_r) begin
          if (prep_r) begin
            state_nxt = S_PR_WR;
          end else begin
            cache_color_nxt = ref_r;
            cache_idx_nxt   = best_idx_r;
            cache_valid_nxt = 1'b1;
            res_nxt         = best_idx_r;
            state_nxt       = S_OUT;
          end
        end
      end
      S_PR_RD: begin
        pal_re    = 1'b1;
        pal_raddr = i_r;
        state_nxt = S_PR_REF;
      end
      S_PR_REF: begin
        ref_nxt     = pal_rdata;
        best_nxt    = NO_NEIGHBOUR;
        cnt_nxt     = '0;
        scan_go_nxt = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_PR_WR: begin
        if (i_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PR_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'(res_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cache_color_r <= '0;
      cache_idx_r   <= '0;
      cache_valid_r <= 1'b0;
      scan_go_r     <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      prep_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cache_color_r <= cache_color_nxt;
      cache_idx_r   <= cache_idx_nxt;
      cache_valid_r <= cache_valid_nxt;
      scan_go_r     <= scan_go_nxt;
      s1_v_r        <= s1_v_nxt;
      s2_v_r        <= s2_v_nxt;
      out_valid_r   <= out_valid_nxt;
      prep_r        <= prep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r         <= ref_nxt;
    cnt_r         <= cnt_nxt;
    i_r           <= i_nxt;
    s1_idx_r      <= s1_idx_nxt;
    s2_idx_r      <= s2_idx_nxt;
    s2_eq_r       <= s2_eq_nxt;
    best_r        <= best_nxt;
    best_idx_r    <= best_idx_nxt;
    res_r         <= res_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
